// ===== rtl/core/pcgxsh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCG XSH-RS generator package
// Shared widths, constants, codes, control structs and the output function
// of the 64-bit multiplicative PCG generator.
// ----------------------------------------------------------------------------
package pcgxsh_pkg;

  localparam int unsigned STATE_W = 64;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned HALF_W  = 16;
  localparam int unsigned CMD_W   = 2;

  // Multiplier of the generator, split into halves for the 32x32 unit.
  localparam logic [STATE_W-1:0] PCG_MULT = 64'h5851_F42D_4C95_7F2D;

  // XSH-RS output: xor shift and base of the random rotate-free shift.
  localparam int unsigned XSH_SHIFT  = 22;
  localparam int unsigned SHIFT_BASE = 22;

  // Request kinds. The fourth code is unused and returns zero.
  typedef enum logic [CMD_W-1:0] {
    CMD_RAW     = 2'd0,
    CMD_BOUNDED = 2'd1,
    CMD_HALF    = 2'd2
  } cmd_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    S_IDLE,
    S_THR,
    S_DRAW,
    S_STEP,
    S_MOD,
    S_DONE
  } seq_state_t;

  // Partial product phases of the state advance.
  typedef enum logic [1:0] {
    PH_LO_LO,
    PH_HI_LO,
    PH_LO_HI
  } mul_phase_t;

  // Control of the generator state unit.
  typedef struct packed {
    logic               load;
    logic               step;
    logic [STATE_W-1:0] seed;
  } draw_ctl_t;

  // Request to the shared remainder unit.
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  // XSH-RS output word of a generator state.
  function automatic logic [WORD_W-1:0] xsh_rs(input logic [STATE_W-1:0] s);
    logic [STATE_W-1:0] mixed;
    logic [4:0]         sh;
    mixed = (s >> XSH_SHIFT) ^ s;
    sh    = 5'(SHIFT_BASE) + {2'b00, s[STATE_W-1 -: 3]};
    return WORD_W'(mixed >> sh);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pcgxsh_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCG request channel
// Valid/ready channel carrying one request: its kind and its bound.
// ----------------------------------------------------------------------------
interface pcgxsh_req_if;
  logic                                valid;
  logic                                ready;
  logic [pcgxsh_pkg::CMD_W-1:0]        cmd;
  logic [pcgxsh_pkg::WORD_W-1:0]       bound;

  modport source (output valid, output cmd, output bound, input ready);
  modport sink   (input valid, input cmd, input bound, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pcgxsh_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCG result channel
// Valid/ready channel carrying one result: the value and the error flag.
// ----------------------------------------------------------------------------
interface pcgxsh_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pcgxsh_pkg::WORD_W-1:0] value;
  logic                          bad_bound;

  modport source (output valid, output value, output bad_bound, input ready);
  modport sink   (input valid, input value, input bad_bound, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pcgxsh_draw.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCG generator state unit
// Holds the 64-bit state, presents its XSH-RS word and advances the state
// by the PCG multiplier through the low-low, high-low and low-high partial products on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module pcgxsh_draw (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire pcgxsh_pkg::draw_ctl_t              ctl,
  output logic                                    busy,
  output logic [pcgxsh_pkg::WORD_W-1:0]           word
);

  localparam int unsigned SW = pcgxsh_pkg::STATE_W;
  localparam int unsigned WW = pcgxsh_pkg::WORD_W;

  logic [SW-1:0]          gen_state;
  logic [SW-1:0]          acc;
  pcgxsh_pkg::mul_phase_t phase;
  logic [WW-1:0]          mul_a;
  logic [WW-1:0]          mul_b;
  logic [SW-1:0]          product;

  // The word always reflects the state that the next draw consumes.
  assign word = pcgxsh_pkg::xsh_rs(gen_state);

  // Operand selection for the three partial products that reach the low
  // 64 bits of the full product.
  always_comb begin
    unique case (phase)
      pcgxsh_pkg::PH_LO_LO: begin
        mul_a = gen_state[WW-1:0];
        mul_b = pcgxsh_pkg::PCG_MULT[WW-1:0];
      end
      pcgxsh_pkg::PH_HI_LO: begin
        mul_a = gen_state[SW-1:WW];
        mul_b = pcgxsh_pkg::PCG_MULT[WW-1:0];
      end
      pcgxsh_pkg::PH_LO_HI: begin
        mul_a = gen_state[WW-1:0];
        mul_b = pcgxsh_pkg::PCG_MULT[SW-1:WW];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = {{WW{1'b0}}, mul_a} * {{WW{1'b0}}, mul_b};

  // Accumulate the partial products; the state is replaced on the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= SW'(1);
      busy      <= 1'b0;
      phase     <= pcgxsh_pkg::PH_LO_LO;
    end else if (ctl.load) begin
      gen_state <= ctl.seed | SW'(1);
      busy      <= 1'b0;
      phase     <= pcgxsh_pkg::PH_LO_LO;
    end else if (ctl.step && !busy) begin
      busy  <= 1'b1;
      phase <= pcgxsh_pkg::PH_LO_LO;
    end else if (busy) begin
      unique case (phase)
        pcgxsh_pkg::PH_LO_LO: begin
          acc   <= product;
          phase <= pcgxsh_pkg::PH_HI_LO;
        end
        pcgxsh_pkg::PH_HI_LO: begin
          acc[SW-1:WW] <= acc[SW-1:WW] + product[WW-1:0];
          phase        <= pcgxsh_pkg::PH_LO_HI;
        end
        pcgxsh_pkg::PH_LO_HI: begin
          gen_state <= {acc[SW-1:WW] + product[WW-1:0], acc[WW-1:0]};
          busy      <= 1'b0;
          phase     <= pcgxsh_pkg::PH_LO_LO;
        end
        default: begin
          busy  <= 1'b0;
          phase <= pcgxsh_pkg::PH_LO_LO;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pcgxsh_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCG remainder unit
// Restoring divider that yields the 32-bit remainder of a 32-bit dividend
// by a non-zero 32-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcgxsh_divider (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire pcgxsh_pkg::div_req_t               req,
  output logic                                    busy,
  output logic [pcgxsh_pkg::WORD_W-1:0]           rem
);

  localparam int unsigned WW    = pcgxsh_pkg::WORD_W;
  localparam int unsigned CNT_W = $clog2(WW);

  logic [WW-1:0]    dvd;
  logic [WW-1:0]    dsr;
  logic [CNT_W-1:0] count;
  logic [WW:0]      rem_sh;
  logic [WW+1:0]    diff;

  // One trial subtraction of the shifted partial remainder.
  assign rem_sh = {rem, dvd[WW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (req.start && !busy) begin
      rem   <= '0;
      dvd   <= req.dividend;
      dsr   <= req.divisor;
      count <= CNT_W'(WW - 1);
      busy  <= 1'b1;
    end else if (busy) begin
      rem   <= diff[WW+1] ? rem_sh[WW-1:0] : diff[WW-1:0];
      dvd   <= {dvd[WW-2:0], 1'b0};
      count <= count - CNT_W'(1);
      if (count == '0) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pcg_xsh_rs_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCG XSH-RS random generator, top level
// Multiplicative 64-bit PCG generator with a 32-bit XSH-RS output, serving
// raw, bounded and 16-bit half requests one at a time.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per transfer (cmd, bound); rsp returns exactly one
//   result per request (value, bad_bound). seed_we with seed_wdata reloads the
//   generator state with the seed forced odd; write it only while idle.
//   req.ready is high only while the sequencer is idle, so one request is in
//   work at a time. A raw word or a new low half passes S_DRAW, then S_STEP
//   while the state advance runs on the shared 32x32 multiplier, then S_DONE;
//   a pending high half, a zero bound or the unused code go straight to S_DONE.
//   A bounded request first works out the threshold in S_THR on the shared
//   one-bit-per-cycle divider, then draws a word through S_DRAW and S_STEP,
//   drawing again for each rejected word, and takes the final remainder in
//   S_MOD before S_DONE.
//   The result sits in an output register; a new request is taken while it
//   waits, and a finished result waits in the sequencer while rsp stalls.
//   Reset loads the state with one and clears the pending half.
// ----------------------------------------------------------------------------
module pcg_xsh_rs_generator (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              seed_we,
  input  wire logic [pcgxsh_pkg::STATE_W-1:0]    seed_wdata,
  pcgxsh_req_if.sink                             req,
  pcgxsh_rsp_if.source                           rsp
);

  localparam int unsigned WW = pcgxsh_pkg::WORD_W;
  localparam int unsigned HW = pcgxsh_pkg::HALF_W;

  pcgxsh_pkg::seq_state_t state, state_next;
  pcgxsh_pkg::draw_ctl_t  draw_ctl;
  pcgxsh_pkg::div_req_t   div_req;
  pcgxsh_pkg::cmd_t       cmd_q;

  logic          draw_busy;
  logic [WW-1:0] draw_word;
  logic          div_busy;
  logic [WW-1:0] div_rem;

  logic [WW-1:0] bound_q;
  logic [WW-1:0] thr;
  logic [WW-1:0] word_q;
  logic [WW-1:0] saved_word;
  logic          half_pending;
  logic [WW-1:0] res_value, res_value_next;
  logic          res_bad, res_bad_next;
  logic [WW-1:0] out_value;
  logic          out_bad;
  logic          out_valid;

  logic req_take;
  logic res_we;
  logic word_we;
  logic thr_we;
  logic half_fill;
  logic half_take;
  logic out_load;

  pcgxsh_draw u_draw (
    .clk  (clk),
    .rst  (rst),
    .ctl  (draw_ctl),
    .busy (draw_busy),
    .word (draw_word)
  );

  pcgxsh_divider u_divider (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .busy (div_busy),
    .rem  (div_rem)
  );

  assign req.ready     = (state == pcgxsh_pkg::S_IDLE);
  assign req_take      = req.valid && req.ready;
  assign rsp.valid     = out_valid;
  assign rsp.value     = out_value;
  assign rsp.bad_bound = out_bad;

  // Sequencer: next state and strobes for the datapath registers.
  always_comb begin
    state_next     = state;
    draw_ctl       = '{load: seed_we, step: 1'b0, seed: seed_wdata};
    div_req        = '{start: 1'b0, dividend: word_q, divisor: bound_q};
    res_we         = 1'b0;
    res_value_next = '0;
    res_bad_next   = 1'b0;
    word_we        = 1'b0;
    thr_we         = 1'b0;
    half_fill      = 1'b0;
    half_take      = 1'b0;
    out_load       = 1'b0;

    unique case (state)
      pcgxsh_pkg::S_IDLE: begin
        if (req_take) begin
          case (pcgxsh_pkg::cmd_t'(req.cmd))
            pcgxsh_pkg::CMD_RAW: begin
              state_next = pcgxsh_pkg::S_DRAW;
            end
            pcgxsh_pkg::CMD_BOUNDED: begin
              if (req.bound == '0) begin
                res_we       = 1'b1;
                res_bad_next = 1'b1;
                state_next   = pcgxsh_pkg::S_DONE;
              end else begin
                // Threshold is (2^32 - bound) mod bound.
                div_req    = '{start: 1'b1, dividend: -req.bound, divisor: req.bound};
                state_next = pcgxsh_pkg::S_THR;
              end
            end
            pcgxsh_pkg::CMD_HALF: begin
              if (half_pending) begin
                res_we         = 1'b1;
                res_value_next = {{(WW-HW){1'b0}}, saved_word[WW-1:HW]};
                half_take      = 1'b1;
                state_next     = pcgxsh_pkg::S_DONE;
              end else begin
                state_next = pcgxsh_pkg::S_DRAW;
              end
            end
            default: begin
              res_we     = 1'b1;
              state_next = pcgxsh_pkg::S_DONE;
            end
          endcase
        end
      end
      pcgxsh_pkg::S_THR: begin
        if (!div_busy) begin
          thr_we     = 1'b1;
          state_next = pcgxsh_pkg::S_DRAW;
        end
      end
      pcgxsh_pkg::S_DRAW: begin
        draw_ctl.step = 1'b1;
        word_we       = 1'b1;
        half_fill     = (cmd_q == pcgxsh_pkg::CMD_HALF);
        state_next    = pcgxsh_pkg::S_STEP;
      end
      pcgxsh_pkg::S_STEP: begin
        if (!draw_busy) begin
          case (cmd_q)
            pcgxsh_pkg::CMD_BOUNDED: begin
              // Reject words below the threshold and draw again.
              if (word_q >= thr) begin
                div_req.start = 1'b1;
                state_next    = pcgxsh_pkg::S_MOD;
              end else begin
                state_next = pcgxsh_pkg::S_DRAW;
              end
            end
            pcgxsh_pkg::CMD_HALF: begin
              res_we         = 1'b1;
              res_value_next = {{(WW-HW){1'b0}}, word_q[HW-1:0]};
              state_next     = pcgxsh_pkg::S_DONE;
            end
            default: begin
              res_we         = 1'b1;
              res_value_next = word_q;
              state_next     = pcgxsh_pkg::S_DONE;
            end
          endcase
        end
      end
      pcgxsh_pkg::S_MOD: begin
        if (!div_busy) begin
          res_we         = 1'b1;
          res_value_next = div_rem;
          state_next     = pcgxsh_pkg::S_DONE;
        end
      end
      pcgxsh_pkg::S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = pcgxsh_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pcgxsh_pkg::S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcgxsh_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pending half and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_pending <= 1'b0;
      saved_word   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (half_fill) begin
        half_pending <= 1'b1;
        saved_word   <= draw_word;
      end else if (half_take) begin
        half_pending <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request, working and result registers.
  always_ff @(posedge clk) begin
    if (req_take) begin
      cmd_q   <= pcgxsh_pkg::cmd_t'(req.cmd);
      bound_q <= req.bound;
    end
    if (thr_we) begin
      thr <= div_rem;
    end
    if (word_we) begin
      word_q <= draw_word;
    end
    if (res_we) begin
      res_value <= res_value_next;
      res_bad   <= res_bad_next;
    end
    if (out_load) begin
      out_value <= res_value;
      out_bad   <= res_bad;
    end
  end

`ifndef SYNTHESIS
  // Only one request is in work: the channel closes after each transfer.
  assert property (@(posedge clk) disable iff (rst) req_take |=> !req.ready)
    else $error("request channel stayed open after a transfer");

  // The multiplier and the divider are never in use at the same time.
  assert property (@(posedge clk) disable iff (rst) !(draw_busy && div_busy))
    else $error("state advance and remainder unit overlap");

  // An error result always carries a zero value.
  assert property (@(posedge clk) disable iff (rst)
                   rsp.valid && rsp.bad_bound |-> rsp.value == '0)
    else $error("bad bound result with non-zero value");
`endif

endmodule
`default_nettype wire

// ===== tb/pcg_xsh_rs_generator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCG XSH-RS generator checker
// Watches the seed port and both channels of the generator. It keeps its own
// copy of the generator state, works out the result of every request taken
// and compares each returned result, field by field, with the oldest one
// still awaited.
// ----------------------------------------------------------------------------
module pcg_xsh_rs_generator_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           seed_we,
  input  logic [pcgxsh_pkg::STATE_W-1:0] seed_wdata,
  pcgxsh_req_if                          req,
  pcgxsh_rsp_if                          rsp,
  output int unsigned                    mismatches,
  output int unsigned                    awaited
);
  import pcgxsh_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct {
    logic [WORD_W-1:0] value;
    logic              bad_bound;
  } gen_result_t;

  // Results still owed by the block, oldest first.
  gen_result_t awaited_results[$];

  // Mirror of the generator.
  logic [STATE_W-1:0] gen_state;
  logic [WORD_W-1:0]  half_word;
  logic               high_half_due;

  // Output word of the current state, then the multiplicative step.
  function automatic logic [WORD_W-1:0] advance_word();
    logic [STATE_W-1:0] mixed;
    logic [4:0]         shift;
    mixed     = (gen_state >> 22) ^ gen_state;
    shift     = {2'b00, gen_state[STATE_W-1 -: 3]} + 5'd22;
    gen_state = gen_state * PCG_MULT;
    return WORD_W'(mixed >> shift);
  endfunction

  // Result of one request, updating the mirrored state as the block does.
  function automatic gen_result_t predict_result(input logic [CMD_W-1:0] kind,
                                                 input logic [WORD_W-1:0] limit);
    gen_result_t        res;
    logic [STATE_W-1:0] wide_floor;
    logic [WORD_W-1:0]  floor_word;
    logic [WORD_W-1:0]  word;
    res.value     = '0;
    res.bad_bound = 1'b0;
    case (kind)
      CMD_RAW: begin
        res.value = advance_word();
      end
      CMD_BOUNDED: begin
        if (limit == '0) begin
          res.bad_bound = 1'b1;
        end else begin
          // Words below (2^32 - bound) mod bound are rejected to remove bias.
          wide_floor = (64'h1_0000_0000 - {32'd0, limit}) % {32'd0, limit};
          floor_word = wide_floor[WORD_W-1:0];
          word       = advance_word();
          while (word < floor_word) word = advance_word();
          res.value = word % limit;
        end
      end
      CMD_HALF: begin
        if (high_half_due) begin
          high_half_due = 1'b0;
          res.value     = {16'd0, half_word[WORD_W-1 -: HALF_W]};
        end else begin
          high_half_due = 1'b1;
          half_word     = advance_word();
          res.value     = {16'd0, half_word[HALF_W-1:0]};
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Returned results are checked before the request of the same edge is added.
  always @(posedge clk) begin : monitor
    gen_result_t got;
    gen_result_t want;
    if (rst) begin
      gen_state     = 64'd1;
      half_word     = '0;
      high_half_due = 1'b0;
      mismatches    = 0;
      awaited_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.value     = rsp.value;
        got.bad_bound = rsp.bad_bound;
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%t: unexpected result value %h bad_bound %b", $realtime,
                     got.value, got.bad_bound);
        end else begin
          want = awaited_results.pop_front();
          if (got.value !== want.value || got.bad_bound !== want.bad_bound) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display({"%t: result mismatch: expected value %h bad_bound %b, ",
                        "got value %h bad_bound %b"},
                       $realtime, want.value, want.bad_bound, got.value, got.bad_bound);
          end
        end
      end
      if (seed_we) gen_state = seed_wdata | 64'd1;
      if (req.valid && req.ready) awaited_results.push_back(predict_result(req.cmd, req.bound));
    end
    awaited = awaited_results.size();
  end

endmodule

// ===== tb/pcg_xsh_rs_generator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCG XSH-RS generator testbench
// Drives directed and random requests through the generator under several
// seeds, with random gaps on both channels, a long result hold-off and a
// drain in mid-stream. The checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module pcg_xsh_rs_generator_test;
  import pcgxsh_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED    = 2'd3;
  localparam int unsigned      HOLD_CYCLES   = 400;
  localparam int unsigned      PHASE_ITEMS   = 205;
  localparam int unsigned      SETTLE_CYCLES = 8;
  localparam int unsigned      SEED_COUNT    = 7;

  logic               clk;
  logic               rst;
  logic               seed_we;
  logic [STATE_W-1:0] seed_wdata;
  bit                 req_idle_en;
  bit                 rsp_idle_en;
  bit                 hold_rsp;
  int unsigned        mismatches;
  int unsigned        awaited;
  logic [STATE_W-1:0] seeds [SEED_COUNT];

  pcgxsh_req_if req_ch ();
  pcgxsh_rsp_if rsp_ch ();

  pcg_xsh_rs_generator i_dut (
    .clk       (clk),
    .rst       (rst),
    .seed_we   (seed_we),
    .seed_wdata(seed_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  pcg_xsh_rs_generator_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .seed_we   (seed_we),
    .seed_wdata(seed_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .mismatches(mismatches),
    .awaited   (awaited)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard limit on the run.
  initial begin
    #12000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: random stalls, and a long hold-off when asked for.
  initial begin : result_side
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rsp = 1'b0;
      end
      rsp_ch.ready <= !(rsp_idle_en && $urandom_range(99) < 30);
    end
  end

  // Offers one request and returns at the edge where it is transferred.
  task automatic send_request(input logic [CMD_W-1:0] kind, input logic [WORD_W-1:0] limit);
    @(negedge clk);
    if (req_idle_en && $urandom_range(99) < 30) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd   <= kind;
    req_ch.bound <= limit;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Stops offering and waits until every awaited result has come back.
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    wait (awaited == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Seed write; the block must be idle, so call after drain.
  task automatic write_seed(input logic [STATE_W-1:0] value);
    seed_we    <= 1'b1;
    seed_wdata <= value;
    @(negedge clk);
    seed_we    <= 1'b0;
  endtask

  // Random request with bounds weighted towards the interesting ranges.
  task automatic random_request();
    logic [CMD_W-1:0]  kind;
    logic [WORD_W-1:0] limit;
    int unsigned       pick;
    pick = $urandom_range(99);
    if (pick < 33) kind = CMD_RAW;
    else if (pick < 66) kind = CMD_BOUNDED;
    else if (pick < 95) kind = CMD_HALF;
    else kind = CMD_UNUSED;
    pick = $urandom_range(99);
    if (pick < 4) limit = '0;
    else if (pick < 30) limit = $urandom_range(1, 16);
    else if (pick < 50) limit = 32'd1 << $urandom_range(0, 31);
    else if (pick < 62) limit = 32'h8000_0000 + $urandom_range(0, 1000);
    else if (pick < 72) limit = 32'hFFFF_FFFF - $urandom_range(0, 1000);
    else limit = $urandom;
    send_request(kind, limit);
  endtask

  // Stimulus and verdict.
  initial begin
    rst          = 1'b1;
    seed_we      = 1'b0;
    seed_wdata   = '0;
    req_ch.valid = 1'b0;
    req_ch.cmd   = CMD_RAW;
    req_ch.bound = '0;
    req_idle_en  = 1'b1;
    rsp_idle_en  = 1'b1;
    hold_rsp     = 1'b0;
    seeds[0] = 64'h0;
    seeds[1] = '1;
    seeds[2] = 64'h8000_0000_0000_0000;
    seeds[3] = {$urandom, $urandom};
    seeds[4] = 64'hFFFF_FFFF_FFFF_FFFE;
    seeds[5] = 64'h1;
    seeds[6] = {$urandom, $urandom};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part on the reset seed: every request kind, the mixing of
    // halves with other kinds, a zero bound, the unused code and extreme
    // bounds, including ones with heavy rejection.
    send_request(CMD_RAW, '0);
    send_request(CMD_HALF, '0);
    send_request(CMD_RAW, '1);
    send_request(CMD_BOUNDED, 32'd10);
    send_request(CMD_HALF, '1);
    send_request(CMD_BOUNDED, 32'd0);
    send_request(CMD_UNUSED, 32'hFFFF_FFFF);
    send_request(CMD_UNUSED, 32'd0);
    send_request(CMD_BOUNDED, 32'd1);
    send_request(CMD_BOUNDED, 32'hFFFF_FFFF);
    send_request(CMD_BOUNDED, 32'h8000_0000);
    send_request(CMD_BOUNDED, 32'h8000_0001);
    send_request(CMD_BOUNDED, 32'd3);
    send_request(CMD_BOUNDED, 32'hAAAA_AAAA);
    send_request(CMD_BOUNDED, 32'h5555_5555);
    send_request(CMD_HALF, '0);
    send_request(CMD_BOUNDED, 32'd0);
    send_request(CMD_HALF, '0);
    // The low half drawn here stays pending across the next seed write.
    send_request(CMD_HALF, '0);

    // Random phases, one per seed.
    for (int p = 0; p < SEED_COUNT; p++) begin
      drain();
      write_seed(seeds[p]);
      req_idle_en = (p != 2);
      rsp_idle_en = (p != 2);
      if (p == 3) hold_rsp = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == 100) drain();
        random_request();
      end
    end

    drain();
    if (mismatches == 0 && awaited == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pcgxsh_pkg.sv
rtl/core/pcgxsh_req_if.sv
rtl/core/pcgxsh_rsp_if.sv
rtl/core/pcgxsh_draw.sv
rtl/core/pcgxsh_divider.sv
rtl/core/pcg_xsh_rs_generator.sv
tb/pcg_xsh_rs_generator_checker.sv
tb/pcg_xsh_rs_generator_test.sv
